>>> sv/ptt_pkg.sv
// Package for the periodic timer table: sizes, codes and shared types.
package ptt_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 48;
  localparam int WAIT_BITS = 48;
  localparam int HANDLE_W  = 16;
  localparam int PERIOD_W  = 32;
  localparam int FUNC_W    = 3;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [FUNC_W-1:0] FUNC_ARM_ABS = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ARM_REL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

  localparam logic KIND_FIRE  = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0]  owner;
    logic [TIME_BITS-1:0] deadline;
    logic [PERIOD_W-1:0]  period;
  } entry_t;

  // per-slot decision from the slot evaluator
  typedef struct packed {
    logic fire;   // slot is due on this tick
    logic live;   // slot valid after the operation
    logic wr;     // entry contents change
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_PRIME,
    ST_SCAN,
    ST_FOLD,
    ST_DONE
  } state_e;

endpackage

>>> sv/ptt_ram.sv
// Slot memory: one write port, one registered read port.
module ptt_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ptt_pkg::IDX_W-1:0] waddr_i,
  input  ptt_pkg::entry_t        wdata_i,
  input  logic [ptt_pkg::IDX_W-1:0] raddr_i,
  output ptt_pkg::entry_t        rdata_o
);

  ptt_pkg::entry_t mem [ptt_pkg::SLOTS];
  ptt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ptt_slot_upd.sv
// Slot evaluator: applies update, cancel or tick to one read entry.
module ptt_slot_upd (
  input  logic [ptt_pkg::FUNC_W-1:0]    func_i,
  input  logic [ptt_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [ptt_pkg::PERIOD_W-1:0]  period_i,
  input  logic [ptt_pkg::TIME_BITS-1:0] now_i,
  input  logic                          valid_i,
  input  ptt_pkg::entry_t               entry_i,
  output ptt_pkg::entry_t               entry_o,
  output ptt_pkg::upd_t                 upd_o
);

  logic                          match;
  logic                          due;
  logic [ptt_pkg::TIME_BITS:0]   sum;
  logic                          catch_up;
  logic [ptt_pkg::TIME_BITS-1:0] from_now;
  logic [ptt_pkg::TIME_BITS-1:0] next_dl;

  assign match    = valid_i && (entry_i.owner == handle_i);
  assign due      = valid_i && (entry_i.deadline <= now_i);
  // exact sum, carry kept for the catch-up test
  assign sum      = {1'b0, entry_i.deadline} + (ptt_pkg::TIME_BITS+1)'(entry_i.period);
  assign catch_up = sum <= {1'b0, now_i};
  assign from_now = now_i + ptt_pkg::TIME_BITS'(entry_i.period);
  assign next_dl  = catch_up ? from_now : sum[ptt_pkg::TIME_BITS-1:0];

  always_comb begin
    entry_o     = entry_i;
    upd_o.fire  = 1'b0;
    upd_o.live  = valid_i;
    upd_o.wr    = 1'b0;
    case (func_i)
      ptt_pkg::FUNC_UPDATE: begin
        if (match) begin
          entry_o.period = period_i;
          upd_o.wr       = 1'b1;
        end
      end
      ptt_pkg::FUNC_CANCEL: begin
        if (match) begin
          upd_o.live = 1'b0;
        end
      end
      ptt_pkg::FUNC_TICK: begin
        if (due) begin
          upd_o.fire = 1'b1;
          if (entry_i.period != '0) begin
            entry_o.deadline = next_dl;
            upd_o.wr         = 1'b1;
          end else begin
            upd_o.live = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/periodic_timer_table_top.sv
// Periodic timer table top level: sequencer, valid marks, earliest-deadline fold, output register.
// Scan: one slot per cycle, except while a due slot waits on a stall of the result channel; the
//   schedule beat enters the output register from DONE after the scan and FOLD (arm adds ARM, PRIME).
// Throughput: one item at a time; the input stalls from acceptance until the schedule beat is
//   registered; the memory's single read port sets the one-slot-per-cycle scan.
// Reset clears the valid marks and the sequencer at once; slot memory is not cleared and is
//   only used for valid slots, so no clearing pass is needed.
module periodic_timer_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ptt_pkg::FUNC_W-1:0]    func_i,
  input  logic [ptt_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [ptt_pkg::TIME_BITS-1:0] time_ms_i,
  input  logic [ptt_pkg::PERIOD_W-1:0]  interval_ms_i,
  input  logic [ptt_pkg::TIME_BITS-1:0] now_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [ptt_pkg::HANDLE_W-1:0]  fired_handle_o,
  output logic [ptt_pkg::WAIT_BITS-1:0] wait_ms_o,
  output logic                          pending_o,
  output logic                          table_full_o,
  output logic                          last_o
);

  localparam int CmpW = (ptt_pkg::TIME_BITS > ptt_pkg::WAIT_BITS) ?
                        ptt_pkg::TIME_BITS : ptt_pkg::WAIT_BITS;
  localparam logic [ptt_pkg::WAIT_BITS-1:0] WaitMax = '1;
  localparam logic [ptt_pkg::IDX_W-1:0]     LastIdx = ptt_pkg::IDX_W'(ptt_pkg::SLOTS - 1);

  // sequencer
  ptt_pkg::state_e state_q, state_d;
  logic [ptt_pkg::IDX_W-1:0] idx_q, idx_d;

  // latched item
  logic [ptt_pkg::FUNC_W-1:0]    func_q;
  logic [ptt_pkg::HANDLE_W-1:0]  handle_q;
  logic [ptt_pkg::PERIOD_W-1:0]  per_q;
  logic [ptt_pkg::TIME_BITS-1:0] now_q;
  logic [ptt_pkg::TIME_BITS-1:0] arm_dl_q;
  logic                          full_q, full_d;

  // valid marks, one flop per slot
  logic [ptt_pkg::SLOTS-1:0] valid_q, valid_d;

  // fold stage and earliest deadline
  logic                          p_live_q;
  logic [ptt_pkg::TIME_BITS-1:0] p_dl_q;
  logic                          any_q, any_d;
  logic [ptt_pkg::TIME_BITS-1:0] min_q, min_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          kind_q;
  logic [ptt_pkg::HANDLE_W-1:0]  fh_q;
  logic [ptt_pkg::WAIT_BITS-1:0] wait_q;
  logic                          pend_q;
  logic                          tfull_q;
  logic                          last_q;

  // memory port
  logic                      ram_we;
  logic [ptt_pkg::IDX_W-1:0] ram_waddr;
  ptt_pkg::entry_t           ram_wdata;
  logic [ptt_pkg::IDX_W-1:0] ram_raddr;
  ptt_pkg::entry_t           ram_rdata;

  // slot evaluation
  ptt_pkg::entry_t upd_entry;
  ptt_pkg::upd_t   upd;

  logic                      in_accept;
  logic                      out_free;
  logic                      advance;
  logic                      emit_fire;
  logic                      emit_sched;
  logic                      free_found;
  logic [ptt_pkg::IDX_W-1:0] free_idx;
  logic [ptt_pkg::WAIT_BITS-1:0] sched_wait;

  assign in_stall_o = (state_q != ptt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  ptt_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptt_slot_upd u_slot_upd (
    .func_i   (func_q),
    .handle_i (handle_q),
    .period_i (per_q),
    .now_i    (now_q),
    .valid_i  (valid_q[idx_q]),
    .entry_i  (ram_rdata),
    .entry_o  (upd_entry),
    .upd_o    (upd)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ptt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = ptt_pkg::IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (func_i == ptt_pkg::FUNC_ARM_ABS || func_i == ptt_pkg::FUNC_ARM_REL) begin
            state_d = ptt_pkg::ST_ARM;
          end else begin
            state_d = ptt_pkg::ST_SCAN;
          end
        end
      end
      ptt_pkg::ST_ARM:   state_d = ptt_pkg::ST_PRIME;
      ptt_pkg::ST_PRIME: state_d = ptt_pkg::ST_SCAN;
      ptt_pkg::ST_SCAN: begin
        if (advance && idx_q == LastIdx) begin
          state_d = ptt_pkg::ST_FOLD;
        end
      end
      ptt_pkg::ST_FOLD:  state_d = ptt_pkg::ST_DONE;
      ptt_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ptt_pkg::ST_IDLE;
        end
      end
      default: state_d = ptt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: memory port and beat emission
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = upd_entry;
    ram_raddr  = '0;
    advance    = 1'b0;
    emit_fire  = 1'b0;
    emit_sched = 1'b0;
    case (state_q)
      ptt_pkg::ST_ARM: begin
        ram_we    = free_found;
        ram_waddr = free_idx;
        ram_wdata = '{owner: handle_q, deadline: arm_dl_q, period: per_q};
      end
      ptt_pkg::ST_SCAN: begin
        // a due slot waits here until its fire beat fits in the output register
        advance   = !upd.fire || out_free;
        emit_fire = upd.fire && out_free;
        ram_we    = advance && upd.wr;
        if (!advance) begin
          ram_raddr = idx_q;
        end else if (idx_q != LastIdx) begin
          ram_raddr = idx_q + ptt_pkg::IDX_W'(1);
        end
      end
      ptt_pkg::ST_DONE: begin
        emit_sched = out_free;
      end
      default: begin
      end
    endcase
  end

  // valid marks, slot index and table-full flag
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    full_d  = full_q;
    if (in_accept) begin
      idx_d  = '0;
      full_d = 1'b0;
    end
    if (state_q == ptt_pkg::ST_ARM) begin
      if (free_found) begin
        valid_d[free_idx] = 1'b1;
      end else begin
        full_d = 1'b1;
      end
    end
    if (advance) begin
      valid_d[idx_q] = upd.live;
      idx_d          = idx_q + ptt_pkg::IDX_W'(1);
    end
  end

  // earliest deadline over the slots that stay valid
  always_comb begin
    any_d = any_q;
    min_d = min_q;
    if (in_accept) begin
      any_d = 1'b0;
    end else if (p_live_q && (!any_q || p_dl_q < min_q)) begin
      any_d = 1'b1;
      min_d = p_dl_q;
    end
  end

  // wait to the earliest deadline: at least one, saturated to the field; zero when no slot stays valid
  always_comb begin
    logic [ptt_pkg::TIME_BITS-1:0] diff;
    logic [CmpW-1:0]               diff_x;
    diff   = (min_q > now_q) ? (min_q - now_q) : ptt_pkg::TIME_BITS'(1);
    diff_x = CmpW'(diff);
    if (!any_q) begin
      sched_wait = '0;
    end else if (diff_x > CmpW'(WaitMax)) begin
      sched_wait = WaitMax;
    end else begin
      sched_wait = ptt_pkg::WAIT_BITS'(diff_x);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire || emit_sched) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptt_pkg::ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      full_q      <= 1'b0;
      any_q       <= 1'b0;
      p_live_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      full_q      <= full_d;
      any_q       <= any_d;
      p_live_q    <= advance && upd.live;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= func_i;
      handle_q <= handle_i;
      per_q    <= interval_ms_i;
      now_q    <= now_ms_i;
      arm_dl_q <= (func_i == ptt_pkg::FUNC_ARM_REL) ? (now_ms_i + time_ms_i) : time_ms_i;
    end
    min_q  <= min_d;
    p_dl_q <= upd_entry.deadline;
    if (emit_fire) begin
      kind_q  <= ptt_pkg::KIND_FIRE;
      fh_q    <= ram_rdata.owner;
      wait_q  <= '0;
      pend_q  <= 1'b0;
      tfull_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (emit_sched) begin
      kind_q  <= ptt_pkg::KIND_SCHED;
      fh_q    <= '0;
      wait_q  <= sched_wait;
      pend_q  <= any_q;
      tfull_q <= full_q;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign fired_handle_o = fh_q;
  assign wait_ms_o      = wait_q;
  assign pending_o      = pend_q;
  assign table_full_o   = tfull_q;
  assign last_o         = last_q;

  // fire beats come from tick scans only
  a_fire_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (func_q == ptt_pkg::FUNC_TICK && state_q == ptt_pkg::ST_SCAN))
    else $error("fire beat outside a tick scan");

  // the final beat of an item is always the schedule result
  a_last_is_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_sched |=> (out_valid_q && last_q && kind_q == ptt_pkg::KIND_SCHED && fh_q == '0))
    else $error("schedule beat malformed");

  // the fold stage only carries slots that left the scan the cycle before
  a_fold_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_live_q |-> $past(state_q) == ptt_pkg::ST_SCAN)
    else $error("fold stage loaded outside the scan");

  // scan writes go back to the slot just read
  a_scan_wb_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == ptt_pkg::ST_SCAN) |-> (ram_waddr == idx_q && advance))
    else $error("write-back to a slot other than the one evaluated");

endmodule
